/* rtl/sbic_pkg.sv */
// ----------------------------------------------------------------------------
// sbic_pkg
// Shared types and constants for the stack bytecode integer core.
// ----------------------------------------------------------------------------
package sbic_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNDER    = 3'd1;
  localparam logic [2:0] ST_OVER     = 3'd2;
  localparam logic [2:0] ST_DIVZ     = 3'd3;
  localparam logic [2:0] ST_BADLOCAL = 3'd4;
  localparam logic [2:0] ST_UNKNOWN  = 3'd5;

  localparam logic [7:0] OP_NOP     = 8'h00;
  localparam logic [7:0] OP_ACNULL  = 8'h01;
  localparam logic [7:0] OP_BIPUSH  = 8'h10;
  localparam logic [7:0] OP_SIPUSH  = 8'h11;
  localparam logic [7:0] OP_ILOAD   = 8'h15;
  localparam logic [7:0] OP_ALOAD   = 8'h19;
  localparam logic [7:0] OP_ISTORE  = 8'h36;
  localparam logic [7:0] OP_ASTORE  = 8'h3A;
  localparam logic [7:0] OP_IINC    = 8'h84;
  localparam logic [7:0] OP_IADD    = 8'h60;
  localparam logic [7:0] OP_ISUB    = 8'h64;
  localparam logic [7:0] OP_IMUL    = 8'h68;
  localparam logic [7:0] OP_IDIV    = 8'h6C;
  localparam logic [7:0] OP_DUP     = 8'h59;
  localparam logic [7:0] OP_DUPX1   = 8'h5A;
  localparam logic [7:0] OP_DUPX2   = 8'h5B;
  localparam logic [7:0] OP_I2B     = 8'h91;
  localparam logic [7:0] OP_I2C     = 8'h92;
  localparam logic [7:0] OP_IFEQ    = 8'h9F;
  localparam logic [7:0] OP_IFNE    = 8'hA0;
  localparam logic [7:0] OP_IFLT    = 8'hA1;
  localparam logic [7:0] OP_IFGE    = 8'hA2;
  localparam logic [7:0] OP_IFGT    = 8'hA3;
  localparam logic [7:0] OP_IFLE    = 8'hA4;
  localparam logic [7:0] OP_GOTO    = 8'hA7;
  localparam logic [7:0] OP_IRETURN = 8'hAC;
  localparam logic [7:0] OP_ARETURN = 8'hB0;
  localparam logic [7:0] OP_RETURN  = 8'hB1;

  // operation class chosen by the front end
  typedef enum logic [3:0] {
    C_NOP, C_PUSHK, C_LOAD, C_STORE, C_IINC, C_ALU, C_DIV, C_DUP, C_DUPX1,
    C_DUPX2, C_CONV, C_CMP, C_GOTO, C_RETV, C_RET, C_PRELOAD
  } op_class_t;

  // decoded request passed from front to back
  typedef struct packed {
    op_class_t   cls;
    logic [7:0]  opcode;
    logic [31:0] imm;
    logic [7:0]  loc;
    logic        loc_bad;
    logic [1:0]  npop;
    logic [2:0]  npush;
    logic [1:0]  len;
    logic        unknown;
    logic [15:0] off;
  } dec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_RD3, S_LRD, S_EXEC, S_DIV, S_WR, S_OUT
  } state_t;

endpackage

/* rtl/stack_bytecode_integer_core.sv */
// ----------------------------------------------------------------------------
// stack_bytecode_integer_core
// Integer bytecode executor with operand stack and local store.
// ----------------------------------------------------------------------------
// Each request carries one fetched instruction or one local preload and
// yields one result. A decode front end queues up to two requests; the back
// end runs one at a time through the stack RAM read port: a dispatch state,
// a read state per popped operand, a local read state for loads and iinc,
// an execute state, a write state per pushed value (at least one) and an
// output state; a request that fails a check goes from dispatch straight to
// output. idiv waits in a divide state for the bit-serial divider. Memories
// are not initialized; reading a never-written local gives an undefined
// value.
module stack_bytecode_integer_core #(
  parameter int STACK_DEPTH = 64,
  parameter int LOCAL_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  opcode,
  input  logic [7:0]  first_byte,
  input  logic [7:0]  second_byte,
  input  logic [7:0]  preload_index,
  input  logic [31:0] preload_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pc_advance,
  output logic        branch_taken,
  output logic        returned,
  output logic        has_return_value,
  output logic [31:0] return_value,
  output logic [6:0]  stack_depth,
  output logic [2:0]  status
);
  import sbic_pkg::*;

  logic q_valid, q_take;
  dec_t q_data;

  sbic_front #(.LOCAL_COUNT(LOCAL_COUNT)) u_front (
    .clk, .rst, .in_valid, .in_stall, .kind, .opcode, .first_byte,
    .second_byte, .preload_index, .preload_value,
    .q_valid, .q_take, .q_data);

  sbic_back #(.STACK_DEPTH(STACK_DEPTH), .LOCAL_COUNT(LOCAL_COUNT)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_data, .out_valid, .out_stall,
    .pc_advance, .branch_taken, .returned, .has_return_value,
    .return_value, .stack_depth, .status);
endmodule

/* rtl/sbic_ram.sv */
// ----------------------------------------------------------------------------
// sbic_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sbic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/sbic_front.sv */
// ----------------------------------------------------------------------------
// sbic_front
// Accepts requests, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sbic_front #(
  parameter int LOCAL_COUNT = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          kind,
  input  logic [7:0]    opcode,
  input  logic [7:0]    first_byte,
  input  logic [7:0]    second_byte,
  input  logic [7:0]    preload_index,
  input  logic [31:0]   preload_value,
  output logic          q_valid,
  input  logic          q_take,
  output sbic_pkg::dec_t q_data
);
  import sbic_pkg::*;

  dec_t d;
  dec_t q0, q1;
  logic v0, v1;
  logic [15:0] off;

  // decode
  always_comb begin
    off = {first_byte, second_byte};
    d = '0;
    d.opcode = opcode;
    d.off = off;
    d.len = 2'd1;
    d.cls = C_NOP;
    if (kind) begin
      d.cls = C_PRELOAD;
      d.loc = preload_index;
      d.imm = preload_value;
      d.len = 2'd0;
    end else begin
      case (opcode) inside
        OP_NOP: d.cls = C_NOP;
        OP_ACNULL: begin d.cls = C_PUSHK; d.npush = 3'd1; end
        [8'h02:8'h08]: begin
          d.cls = C_PUSHK; d.npush = 3'd1; d.imm = 32'(opcode) - 32'd3;
        end
        OP_BIPUSH: begin
          d.cls = C_PUSHK; d.npush = 3'd1; d.len = 2'd2;
          d.imm = {{24{first_byte[7]}}, first_byte};
        end
        OP_SIPUSH: begin
          d.cls = C_PUSHK; d.npush = 3'd1; d.len = 2'd3;
          d.imm = {{16{off[15]}}, off};
        end
        OP_ILOAD, OP_ALOAD: begin
          d.cls = C_LOAD; d.npush = 3'd1; d.len = 2'd2; d.loc = first_byte;
        end
        OP_ISTORE, OP_ASTORE: begin
          d.cls = C_STORE; d.npop = 2'd1; d.len = 2'd2; d.loc = first_byte;
        end
        [8'h1A:8'h1D]: begin d.cls = C_LOAD; d.npush = 3'd1; d.loc = opcode - 8'h1A; end
        [8'h2A:8'h2D]: begin d.cls = C_LOAD; d.npush = 3'd1; d.loc = opcode - 8'h2A; end
        [8'h3B:8'h3E]: begin d.cls = C_STORE; d.npop = 2'd1; d.loc = opcode - 8'h3B; end
        [8'h4B:8'h4E]: begin d.cls = C_STORE; d.npop = 2'd1; d.loc = opcode - 8'h4B; end
        OP_IINC: begin
          d.cls = C_IINC; d.len = 2'd3; d.loc = first_byte;
          d.imm = {{24{second_byte[7]}}, second_byte};
        end
        OP_IADD, OP_ISUB, OP_IMUL: begin d.cls = C_ALU; d.npop = 2'd2; d.npush = 3'd1; end
        OP_IDIV: begin d.cls = C_DIV; d.npop = 2'd2; d.npush = 3'd1; end
        OP_DUP: begin d.cls = C_DUP; d.npop = 2'd1; d.npush = 3'd2; end
        OP_DUPX1: begin d.cls = C_DUPX1; d.npop = 2'd2; d.npush = 3'd3; end
        OP_DUPX2: begin d.cls = C_DUPX2; d.npop = 2'd3; d.npush = 3'd4; end
        OP_I2B, OP_I2C: begin d.cls = C_CONV; d.npop = 2'd1; d.npush = 3'd1; end
        [OP_IFEQ:OP_IFLE]: begin d.cls = C_CMP; d.npop = 2'd2; d.len = 2'd3; end
        OP_GOTO: begin d.cls = C_GOTO; d.len = 2'd3; end
        OP_IRETURN, OP_ARETURN: begin d.cls = C_RETV; d.npop = 2'd1; end
        OP_RETURN: d.cls = C_RET;
        default: d.unknown = 1'b1;
      endcase
    end
    d.loc_bad = (9'(d.loc) >= 9'(LOCAL_COUNT)) &&
                (d.cls == C_LOAD || d.cls == C_STORE || d.cls == C_IINC ||
                 d.cls == C_PRELOAD);
  end

  assign in_stall = v1;
  assign q_valid  = v0;
  assign q_data   = q0;

  // two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (q_take) begin
        v0 <= v1 || (in_valid && !in_stall);
        v1 <= 1'b0;
        q0 <= v1 ? q1 : d;
      end else if (in_valid && !in_stall) begin
        if (!v0) begin
          v0 <= 1'b1; q0 <= d;
        end else begin
          v1 <= 1'b1; q1 <= d;
        end
      end
    end
  end
endmodule

/* rtl/sbic_div.sv */
// ----------------------------------------------------------------------------
// sbic_div
// Iterative signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module sbic_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] q
);
  logic [31:0] rem, quo, dv;
  logic [5:0]  cnt;
  logic        busy, neg;
  logic [32:0] trial;

  assign trial = {1'b0, rem[30:0], quo[31]} - {1'b0, dv};

  // shift-subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        quo  <= a[31] ? -a : a;
        dv   <= b[31] ? -b : b;
        neg  <= a[31] ^ b[31];
      end else if (busy) begin
        if (!trial[32]) rem <= trial[31:0];
        else rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], ~trial[32]};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign q = neg ? -quo : quo;
endmodule

/* rtl/sbic_back.sv */
// ----------------------------------------------------------------------------
// sbic_back
// Executes decoded requests against the operand stack and locals.
// ----------------------------------------------------------------------------
module sbic_back #(
  parameter int STACK_DEPTH = 64,
  parameter int LOCAL_COUNT = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_take,
  input  sbic_pkg::dec_t q_data,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [15:0]    pc_advance,
  output logic           branch_taken,
  output logic           returned,
  output logic           has_return_value,
  output logic [31:0]    return_value,
  output logic [6:0]     stack_depth,
  output logic [2:0]     status
);
  import sbic_pkg::*;

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(LOCAL_COUNT);
  localparam int PW = $clog2(STACK_DEPTH + 1);

  state_t state, state_next;
  dec_t   cur;
  logic [PW-1:0] sp;
  logic [31:0] ra, rb, rc, res, lval;
  logic [2:0]  err;
  logic [1:0]  wcnt;

  // stack and local memory ports
  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [31:0]   s_wdata, s_rdata;
  logic          l_we;
  logic [LW-1:0] l_waddr;
  logic [31:0]   l_wdata, l_rdata;

  logic        dv_start, dv_done;
  logic [31:0] dv_q;

  sbic_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata));

  sbic_ram #(.WIDTH(32), .DEPTH(LOCAL_COUNT)) u_locals (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(cur.loc[LW-1:0]), .rdata(l_rdata));

  sbic_div u_div (.clk, .rst, .start(dv_start), .a(rb), .b(ra),
    .done(dv_done), .q(dv_q));

  // checks in priority order
  logic [PW+1:0] after;
  always_comb begin
    after = (PW+2)'(sp) - (PW+2)'(q_data.npop) + (PW+2)'(q_data.npush);
    if (q_data.unknown) err = ST_UNKNOWN;
    else if ((PW+2)'(sp) < (PW+2)'(q_data.npop)) err = ST_UNDER;
    else if (after > (PW+2)'(STACK_DEPTH)) err = ST_OVER;
    else if (q_data.loc_bad) err = ST_BADLOCAL;
    else err = ST_OK;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_valid) begin
        if (err != ST_OK) state_next = S_OUT;
        else if (q_data.npop != 2'd0) state_next = S_RD1;
        else if (q_data.cls == C_LOAD || q_data.cls == C_IINC) state_next = S_LRD;
        else state_next = S_EXEC;
      end
      S_RD1: state_next = (cur.npop > 2'd1) ? S_RD2 : S_EXEC;
      S_RD2: state_next = (cur.npop > 2'd2) ? S_RD3 : S_EXEC;
      S_RD3: state_next = S_EXEC;
      S_LRD: state_next = S_EXEC;
      S_EXEC: begin
        if (cur.cls == C_DIV && ra != 32'd0) state_next = S_DIV;
        else state_next = S_WR;
      end
      S_DIV: if (dv_done) state_next = S_WR;
      S_WR: if (wcnt == 2'd0 || npush_eff == 3'd0) state_next = S_OUT;
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // values pushed, in push order; vbase is the first slot written
  logic [31:0] pv [4];
  logic [PW-1:0] vbase;
  logic [2:0] npush_eff;
  logic cond;
  always_comb begin
    cond = 1'b0;
    case (cur.opcode)
      OP_IFEQ: cond = rb == ra;
      OP_IFNE: cond = rb != ra;
      OP_IFLT: cond = $signed(rb) < $signed(ra);
      OP_IFGE: cond = !($signed(rb) < $signed(ra));
      OP_IFGT: cond = $signed(ra) < $signed(rb);
      OP_IFLE: cond = !($signed(ra) < $signed(rb));
      default: cond = 1'b0;
    endcase
    pv[0] = res; pv[1] = '0; pv[2] = '0; pv[3] = '0;
    case (cur.cls)
      C_DUP: begin pv[0] = ra; pv[1] = ra; end
      C_DUPX1: begin pv[0] = ra; pv[1] = rb; pv[2] = ra; end
      C_DUPX2: begin pv[0] = ra; pv[1] = rc; pv[2] = rb; pv[3] = ra; end
      default: ;
    endcase
    vbase = sp - PW'(cur.npop);
    npush_eff = cur.npush;
  end

  assign dv_start = (state == S_EXEC) && cur.cls == C_DIV && ra != 32'd0;

  // memory control
  always_comb begin
    s_we = 1'b0; s_waddr = '0; s_wdata = pv[0];
    s_raddr = SW'(sp - PW'(1));
    l_we = 1'b0; l_waddr = cur.loc[LW-1:0]; l_wdata = res;
    case (state)
      S_IDLE: s_raddr = SW'(sp - PW'(1));
      S_RD1: s_raddr = SW'(sp - PW'(2));
      S_RD2: s_raddr = SW'(sp - PW'(3));
      S_WR: if (npush_eff != 3'd0) begin
        s_we = 1'b1;
        s_waddr = SW'(vbase + PW'(npush_eff) - PW'(wcnt) - PW'(1));
        s_wdata = pv[npush_eff[1:0] - wcnt - 2'd1];
      end
      S_EXEC: begin
        if (cur.cls == C_PRELOAD) begin
          l_we = 1'b1; l_wdata = cur.imm;
        end
        if (cur.cls == C_STORE) begin
          l_we = 1'b1; l_wdata = ra;
        end
        if (cur.cls == C_IINC) begin
          l_we = 1'b1; l_wdata = l_rdata + cur.imm;
        end
      end
      default: ;
    endcase
  end

  // exec result
  logic [31:0] prod;
  always_comb begin
    res = cur.imm;
    prod = rb * ra;
    case (cur.cls)
      C_LOAD: res = lval;
      C_ALU: begin
        if (cur.opcode == OP_IADD) res = rb + ra;
        else if (cur.opcode == OP_ISUB) res = rb - ra;
        else res = prod;
      end
      C_DIV: res = dv_q;
      C_CONV: res = (cur.opcode == OP_I2B) ? {{24{ra[7]}}, ra[7:0]} : {16'h0, ra[15:0]};
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (q_valid) begin
          cur <= q_data;
          status <= err;
          pc_advance <= (err == ST_UNKNOWN) ? 16'd1 : 16'(q_data.len);
          branch_taken <= 1'b0; returned <= 1'b0;
          has_return_value <= 1'b0; return_value <= '0;
          wcnt <= 2'(q_data.npush - 3'd1);
        end
        S_RD1: ra <= s_rdata;
        S_RD2: rb <= s_rdata;
        S_RD3: rc <= s_rdata;
        S_LRD: ;
        S_EXEC: begin
          lval <= l_rdata;
          if (cur.cls == C_DIV && ra == 32'd0) begin
            status <= ST_DIVZ;
            cur.npush <= 3'd0;
          end else begin
            case (cur.cls)
              C_CMP: if (cond) begin
                branch_taken <= 1'b1; pc_advance <= cur.off;
              end
              C_GOTO: begin branch_taken <= 1'b1; pc_advance <= cur.off; end
              C_RETV: begin
                returned <= 1'b1; has_return_value <= 1'b1;
                return_value <= ra; pc_advance <= '0; sp <= '0;
                cur.npush <= 3'd0;
              end
              C_RET: begin
                returned <= 1'b1; pc_advance <= '0; sp <= '0; cur.npush <= 3'd0;
              end
              default: ;
            endcase
            if (cur.cls == C_PRELOAD) pc_advance <= '0;
          end
        end
        S_WR: begin
          wcnt <= wcnt - 2'd1;
          if (status == ST_OK && cur.cls != C_RETV && cur.cls != C_RET &&
              (wcnt == 2'd0 || npush_eff == 3'd0))
            sp <= vbase + PW'(npush_eff);
        end
        default: ;
      endcase
      if (state == S_DIV && dv_done) ra <= ra;
    end
  end

  // handshake to the queue and the result channel
  assign q_take = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);
  assign stack_depth = 7'(sp);
endmodule
